// ----- sv/irhd_pkg.sv -----
package irhd_pkg;

    localparam int MESSAGE_BITS = 24;
    localparam int CW_BITS      = 30;
    localparam logic [31:0] DATA_MASK = 32'((64'd1 << MESSAGE_BITS) - 64'd1);
    localparam logic [31:0] NEC_LOW_MASK = 32'h00FF00FF;

    typedef enum logic [1:0] {
        OP_NEC_ENC = 2'd0,
        OP_NEC_DEC = 2'd1,
        OP_MSG_ENC = 2'd2,
        OP_MSG_DEC = 2'd3
    } t_op;

    typedef struct packed {
        t_op         operation;
        logic [31:0] word_in;
    } t_req;

    typedef struct packed {
        logic [31:0] word_out;
        logic        nec_check_failed;
        logic        parity_failed;
    } t_rsp;

    // positions p with bit k set, position p at bit CW_BITS-1-p
    function automatic logic [CW_BITS-1:0] par_mask(int k);
        logic [CW_BITS-1:0] m;
        m = '0;
        for (int p = 1; p < CW_BITS; p++) begin
            if (((p >> k) & 1) != 0) begin
                m[CW_BITS-1-p] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic [31:0] nec_encode(logic [31:0] w);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = w[7:0];
        hi = w[15:8];
        return {hi, ~hi, lo, ~lo};
    endfunction

    function automatic t_rsp nec_decode(logic [31:0] w);
        logic [31:0] comp;
        logic [31:0] tb;
        t_rsp        r;
        comp = ~w & NEC_LOW_MASK;
        tb   = {8'h00, w[31:8]} & NEC_LOW_MASK;
        r.word_out         = {16'h0000, tb[23:16], tb[7:0]};
        r.nec_check_failed = (comp != tb);
        r.parity_failed    = 1'b0;
        return r;
    endfunction

    function automatic logic [31:0] msg_encode(logic [31:0] w);
        logic [23:0]        d;
        logic [CW_BITS-1:0] c;
        logic [CW_BITS-1:0] dc;
        d = w[23:0] & DATA_MASK[23:0];
        c = '0;
        c[12:0]  = d[12:0];
        c[20:14] = d[19:13];
        c[24:22] = d[22:20];
        c[26]    = d[23];
        for (int k = 0; k < 5; k++) begin
            c[CW_BITS-1-(1 << k)] = ^(c & par_mask(k));
        end
        c[CW_BITS-1] = ^c[CW_BITS-2:0];
        // running xor from the msb
        for (int i = 0; i < CW_BITS; i++) begin
            dc[i] = ^(c >> i);
        end
        return {2'b00, dc};
    endfunction

    function automatic t_rsp msg_decode(logic [31:0] w);
        logic [CW_BITS-1:0] c;
        logic [23:0]        d;
        t_rsp               r;
        c = w[CW_BITS-1:0] ^ w[CW_BITS:1];
        d = {c[26], c[24:22], c[20:14], c[12:0]};
        r.word_out         = {8'h00, d} & DATA_MASK;
        r.nec_check_failed = 1'b0;
        r.parity_failed    = ^c;
        return r;
    endfunction

endpackage

// ----- sv/irhd_core.sv -----
module irhd_core (
    input  irhd_pkg::t_req i_req,
    output irhd_pkg::t_rsp o_rsp
);

    always_comb begin
        unique case (i_req.operation)
            irhd_pkg::OP_NEC_ENC: begin
                o_rsp.word_out         = irhd_pkg::nec_encode(i_req.word_in);
                o_rsp.nec_check_failed = 1'b0;
                o_rsp.parity_failed    = 1'b0;
            end
            irhd_pkg::OP_NEC_DEC: begin
                o_rsp = irhd_pkg::nec_decode(i_req.word_in);
            end
            irhd_pkg::OP_MSG_ENC: begin
                o_rsp.word_out         = irhd_pkg::msg_encode(i_req.word_in);
                o_rsp.nec_check_failed = 1'b0;
                o_rsp.parity_failed    = 1'b0;
            end
            irhd_pkg::OP_MSG_DEC: begin
                o_rsp = irhd_pkg::msg_decode(i_req.word_in);
            end
            default: begin
                o_rsp = '0;
            end
        endcase
    end

endmodule

// ----- sv/ir_hamming_differential_codec.sv -----
// channel   | ports                       | handshake
// ----------+-----------------------------+-------------------------------
// request   | i_req (operation, word_in)  | taken when start && !busy
// result    | o_rsp (word_out, flags)     | o_valid for one cycle, no stall
//
// one request per cycle; after the request is taken the result passes through
// the input register, codec logic and result register
// busy is never raised; requests flow back to back
// synchronous active-low reset clears the valid pipeline only
module ir_hamming_differential_codec (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  irhd_pkg::t_req i_req,
    output logic           o_valid,
    output irhd_pkg::t_rsp o_rsp
);

    logic           r_req_valid;
    irhd_pkg::t_req r_req;
    logic           r_rsp_valid;
    irhd_pkg::t_rsp r_rsp;
    irhd_pkg::t_rsp n_rsp;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_req_valid <= start && !busy;
            r_rsp_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= i_req;
        r_rsp <= n_rsp;
    end

    irhd_core u_core (
        .i_req (r_req),
        .o_rsp (n_rsp)
    );

    assign o_valid = r_rsp_valid;
    assign o_rsp   = r_rsp;

endmodule

// ----- sv/irhd_checker.sv -----
module irhd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input irhd_pkg::t_req i_req,
    input logic           o_valid,
    input irhd_pkg::t_rsp o_rsp
);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("result missing two cycles after request");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> ##1 !o_valid)
        else $error("result without request");

    a_nec_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_req.operation, 2) != irhd_pkg::OP_NEC_DEC)
        |-> !o_rsp.nec_check_failed)
        else $error("nec flag outside nec decode");

    a_parity_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_req.operation, 2) != irhd_pkg::OP_MSG_DEC)
        |-> !o_rsp.parity_failed)
        else $error("parity flag outside message decode");

endmodule

bind ir_hamming_differential_codec irhd_checker u_irhd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_valid (o_valid),
    .o_rsp   (o_rsp)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [31:0] MSG_MASK = 32'((64'd1 << irhd_pkg::MESSAGE_BITS) - 64'd1);

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    irhd_pkg::t_req i_req;
    logic o_valid;
    irhd_pkg::t_rsp o_rsp;

    irhd_pkg::t_rsp pending_rsp[$];
    int   mismatch_count = 0;
    int   idle_cycles = 0;
    int   send_idle_pct = 0;

    ir_hamming_differential_codec dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic is_pow2(int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    function automatic irhd_pkg::t_rsp codec_predict(irhd_pkg::t_req r);
        irhd_pkg::t_rsp res;
        logic [29:0]    cw;
        logic [31:0]    w;
        logic [31:0]    data;
        logic           acc;
        int             j;
        w    = r.word_in;
        res  = '0;
        cw   = '0;
        data = '0;
        case (r.operation)
            irhd_pkg::OP_NEC_ENC: begin
                res.word_out = {w[15:8], ~w[15:8], w[7:0], ~w[7:0]};
            end
            irhd_pkg::OP_NEC_DEC: begin
                res.word_out = {16'h0000, w[31:24], w[15:8]};
                res.nec_check_failed = (w[31:24] != ~w[23:16]) || (w[15:8] != ~w[7:0]);
            end
            irhd_pkg::OP_MSG_ENC: begin
                data = w & MSG_MASK & 32'h00FF_FFFF;
                j = 0;
                for (int p = 29; p > 0; p--) begin
                    if (!is_pow2(p)) begin
                        cw[29 - p] = data[j];
                        j++;
                    end
                end
                for (int k = 0; k < 5; k++) begin
                    acc = 1'b0;
                    for (int p = 1; p < 30; p++) begin
                        if (!is_pow2(p) && ((p >> k) & 1)) begin
                            acc ^= cw[29 - p];
                        end
                    end
                    cw[29 - (1 << k)] = acc;
                end
                cw[29] = ^cw[28:0];
                acc = 1'b0;
                for (int i = 29; i >= 0; i--) begin
                    acc ^= cw[i];
                    res.word_out[i] = acc;
                end
            end
            default: begin
                for (int i = 0; i < 30; i++) begin
                    cw[i] = w[i] ^ w[i + 1];
                end
                res.parity_failed = ^cw;
                j = 0;
                for (int p = 29; p > 0; p--) begin
                    if (!is_pow2(p)) begin
                        data[j] = cw[29 - p];
                        j++;
                    end
                end
                res.word_out = data & MSG_MASK;
            end
        endcase
        return res;
    endfunction

    task automatic send_request(irhd_pkg::t_op op, logic [31:0] word);
        irhd_pkg::t_req r;
        r.operation = op;
        r.word_in   = word;
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        pending_rsp.push_back(codec_predict(r));
    endtask

    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    irhd_pkg::t_rsp want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_rsp.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result word_out=%h", o_rsp.word_out);
                end
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.word_out !== want.word_out
                    || o_rsp.nec_check_failed !== want.nec_check_failed
                    || o_rsp.parity_failed !== want.parity_failed) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: want word=%h nec=%b par=%b",
                                 want.word_out, want.nec_check_failed,
                                 want.parity_failed,
                                 " got word=%h nec=%b par=%b",
                                 o_rsp.word_out, o_rsp.nec_check_failed,
                                 o_rsp.parity_failed);
                    end
                end
            end
        end
    end

    function automatic logic [31:0] nec_pair(logic [15:0] v);
        irhd_pkg::t_req r;
        irhd_pkg::t_rsp res;
        r.operation = irhd_pkg::OP_NEC_ENC;
        r.word_in   = {16'h0000, v};
        res = codec_predict(r);
        return res.word_out;
    endfunction

    function automatic logic [31:0] msg_codeword(logic [31:0] v);
        irhd_pkg::t_req r;
        irhd_pkg::t_rsp res;
        r.operation = irhd_pkg::OP_MSG_ENC;
        r.word_in   = v;
        res = codec_predict(r);
        return res.word_out;
    endfunction

    task automatic test_nec_encode();
        send_request(irhd_pkg::OP_NEC_ENC, 32'h0000_0000);
        send_request(irhd_pkg::OP_NEC_ENC, 32'hFFFF_FFFF);
        send_request(irhd_pkg::OP_NEC_ENC, 32'hA5C3_1234);
        send_request(irhd_pkg::OP_NEC_ENC, 32'h0000_00FF);
    endtask

    task automatic test_nec_decode();
        send_request(irhd_pkg::OP_NEC_DEC, nec_pair(16'h1234));
        send_request(irhd_pkg::OP_NEC_DEC, nec_pair(16'hFF00));
        send_request(irhd_pkg::OP_NEC_DEC, 32'h0000_0000);
        send_request(irhd_pkg::OP_NEC_DEC, 32'hFFFF_FFFF);
        send_request(irhd_pkg::OP_NEC_DEC, nec_pair(16'h5A5A) ^ 32'h0001_0000);
    endtask

    task automatic test_msg_encode();
        send_request(irhd_pkg::OP_MSG_ENC, 32'h0000_0000);
        send_request(irhd_pkg::OP_MSG_ENC, 32'hFFFF_FFFF);
        send_request(irhd_pkg::OP_MSG_ENC, 32'h00FF_FFFF);
        send_request(irhd_pkg::OP_MSG_ENC, 32'h0080_0001);
        send_request(irhd_pkg::OP_MSG_ENC, 32'hFF00_0000);
    endtask

    task automatic test_msg_decode();
        send_request(irhd_pkg::OP_MSG_DEC, 32'h0000_0000);
        send_request(irhd_pkg::OP_MSG_DEC, 32'hFFFF_FFFF);
        send_request(irhd_pkg::OP_MSG_DEC, 32'hC000_0000);
        send_request(irhd_pkg::OP_MSG_DEC, 32'h8000_0000);
        send_request(irhd_pkg::OP_MSG_DEC, msg_codeword(32'h00AB_CDEF));
        send_request(irhd_pkg::OP_MSG_DEC, msg_codeword(32'h00AB_CDEF) ^ 32'h0000_0400);
        send_request(irhd_pkg::OP_MSG_DEC, msg_codeword(32'h00FF_FFFF));
    endtask

    task automatic test_random(int count, int idle_pct);
        irhd_pkg::t_op op;
        logic [31:0]   word;
        int            flip;
        send_idle_pct = idle_pct;
        for (int n = 0; n < count; n++) begin
            op   = irhd_pkg::t_op'($urandom_range(3));
            word = $urandom;
            flip = $urandom_range(31);
            if (op == irhd_pkg::OP_NEC_DEC && $urandom_range(3) != 0) begin
                word = nec_pair(word[15:0]);
                if ($urandom_range(3) == 0) begin
                    word[flip] = ~word[flip];
                end
            end else if (op == irhd_pkg::OP_MSG_DEC && $urandom_range(3) != 0) begin
                word = msg_codeword(word);
                if ($urandom_range(2) == 0) begin
                    word[flip] = ~word[flip];
                end
            end
            send_request(op, word);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_req   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_nec_encode();
        test_nec_decode();
        test_msg_encode();
        test_msg_decode();
        test_random(270, 25);
        test_random(270, 76);
        test_random(270, 0);
        start <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- ir_hamming_differential_codec.f -----
sv/irhd_pkg.sv
sv/irhd_core.sv
sv/ir_hamming_differential_codec.sv
sv/irhd_checker.sv
tb/testbench.sv
